### rtl/cbpt_pkg.sv
package cbpt_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_GAMMA_COS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_GAMMA_SIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_QUAT_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_QUAT_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_QUAT_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_QUAT_W   = 3'd5;

    localparam logic signed [15:0] RST_HALF_GAMMA_COS = 16'sd23170;
    localparam logic signed [15:0] RST_HALF_GAMMA_SIN = -16'sd23170;
    localparam logic signed [15:0] RST_MOUNT_QUAT_X   = 16'sd0;
    localparam logic signed [15:0] RST_MOUNT_QUAT_Y   = 16'sd0;
    localparam logic signed [15:0] RST_MOUNT_QUAT_Z   = 16'sd23170;
    localparam logic signed [15:0] RST_MOUNT_QUAT_W   = 16'sd23170;

    localparam int QX = 0;
    localparam int QY = 1;
    localparam int QZ = 2;
    localparam int QW = 3;

    localparam int POS_LAT    = 4;
    localparam int PROD_LAT   = 4;
    localparam int SQRT_STEPS = 26;
    localparam int DIV_STEPS  = 17;
    localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam int P2_W   = 50;
    localparam int LEN_W  = 6;
    localparam int U_W    = 25;
    localparam int SQ_W   = 49;
    localparam int RAD_W  = 52;
    localparam int ROOT_W = 26;
    localparam int REM_W  = 43;
    localparam int DEN_W  = 27;

    typedef logic signed [15:0]     q15_t;
    typedef logic signed [P2_W-1:0] prod_t;
    typedef logic signed [U_W-1:0]  scaled_t;

    typedef struct packed {
        logic signed [31:0] cam_pos_x;
        logic signed [31:0] cam_pos_y;
        logic signed [31:0] cam_pos_z;
        logic signed [15:0] cam_quat_x;
        logic signed [15:0] cam_quat_y;
        logic signed [15:0] cam_quat_z;
        logic signed [15:0] cam_quat_w;
    } cbpt_in_t;

    typedef struct packed {
        logic signed [31:0] body_pos_x;
        logic signed [31:0] body_pos_y;
        logic signed [31:0] body_pos_z;
        logic signed [15:0] body_quat_x;
        logic signed [15:0] body_quat_y;
        logic signed [15:0] body_quat_z;
        logic signed [15:0] body_quat_w;
    } cbpt_out_t;

endpackage

### rtl/cbpt_pos_rot.sv
module cbpt_pos_rot (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cbpt_pkg::q15_t     c,
    input  cbpt_pkg::q15_t     s,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output logic               out_valid,
    output logic signed [31:0] bx,
    output logic signed [31:0] by,
    output logic signed [31:0] bz
);
    import cbpt_pkg::*;

    logic [POS_LAT-1:0] vld_reg;

    logic signed [31:0] cc_reg, ss_reg, cs_reg;
    logic signed [31:0] px1_reg, py1_reg, pz1_reg;
    logic signed [32:0] cg_reg, sg_reg;
    logic signed [31:0] px2_reg, py2_reg, pz2_reg;
    logic signed [64:0] mcx_reg, msy_reg, msx_reg, mcy_reg;
    logic signed [31:0] pz3_reg;
    logic signed [31:0] bx_reg, by_reg, bz_reg;

    logic signed [64:0] mcx_next, msy_next, msx_next, mcy_next;
    logic signed [65:0] sumx, sumy, shx, shy;
    logic signed [31:0] bx_next, by_next;

    always_comb
    begin
        mcx_next = cg_reg * px2_reg;
        msy_next = sg_reg * py2_reg;
        msx_next = sg_reg * px2_reg;
        mcy_next = cg_reg * py2_reg;
    end

    always_comb
    begin
        sumx = mcx_reg + msy_reg + 66'sd536870912;
        sumy = mcy_reg - msx_reg + 66'sd536870912;
        shx  = sumx >>> 30;
        shy  = sumy >>> 30;
        if (shx > 66'sd2147483647)
            bx_next = 32'sh7fffffff;
        else if (shx < -66'sd2147483648)
            bx_next = 32'sh80000000;
        else
            bx_next = shx[31:0];
        if (shy > 66'sd2147483647)
            by_next = 32'sh7fffffff;
        else if (shy < -66'sd2147483648)
            by_next = 32'sh80000000;
        else
            by_next = shy[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[POS_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        cc_reg  <= c * c;
        ss_reg  <= s * s;
        cs_reg  <= c * s;
        px1_reg <= px;
        py1_reg <= py;
        pz1_reg <= pz;

        cg_reg  <= 33'(cc_reg) - 33'(ss_reg);
        sg_reg  <= {cs_reg, 1'b0};
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;
        pz2_reg <= pz1_reg;

        mcx_reg <= mcx_next;
        msy_reg <= msy_next;
        msx_reg <= msx_next;
        mcy_reg <= mcy_next;
        pz3_reg <= pz2_reg;

        bx_reg  <= bx_next;
        by_reg  <= by_next;
        bz_reg  <= pz3_reg;
    end

    assign out_valid = vld_reg[POS_LAT-1];
    assign bx        = bx_reg;
    assign by        = by_reg;
    assign bz        = bz_reg;

endmodule

### rtl/cbpt_quat_prod.sv
module cbpt_quat_prod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cbpt_pkg::q15_t  c,
    input  cbpt_pkg::q15_t  s,
    input  cbpt_pkg::q15_t  cam [4],
    input  cbpt_pkg::q15_t  mnt [4],
    output logic            out_valid,
    output cbpt_pkg::prod_t p2 [4]
);
    import cbpt_pkg::*;

    logic [PROD_LAT-1:0] vld_reg;

    logic signed [31:0] ccx_reg, scy_reg, ccy_reg, scx_reg;
    logic signed [31:0] ccz_reg, scw_reg, ccw_reg, scz_reg;
    logic signed [32:0] p1_reg [4];
    logic signed [47:0] m_reg [4][4];
    prod_t              p2_reg [4];

    logic signed [47:0] m_next [4][4];
    prod_t              p2_next [4];

    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                m_next[a][b] = p1_reg[a] * mnt[b];
            end
        end
    end

    always_comb
    begin
        p2_next[QW] = P2_W'(m_reg[QW][QW]) - P2_W'(m_reg[QX][QX])
                    - P2_W'(m_reg[QY][QY]) - P2_W'(m_reg[QZ][QZ]);
        p2_next[QX] = P2_W'(m_reg[QW][QX]) + P2_W'(m_reg[QX][QW])
                    + P2_W'(m_reg[QY][QZ]) - P2_W'(m_reg[QZ][QY]);
        p2_next[QY] = P2_W'(m_reg[QW][QY]) - P2_W'(m_reg[QX][QZ])
                    + P2_W'(m_reg[QY][QW]) + P2_W'(m_reg[QZ][QX]);
        p2_next[QZ] = P2_W'(m_reg[QW][QZ]) + P2_W'(m_reg[QX][QY])
                    - P2_W'(m_reg[QY][QX]) + P2_W'(m_reg[QZ][QW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PROD_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        ccx_reg <= c * cam[QX];
        scy_reg <= s * cam[QY];
        ccy_reg <= c * cam[QY];
        scx_reg <= s * cam[QX];
        ccz_reg <= c * cam[QZ];
        scw_reg <= s * cam[QW];
        ccw_reg <= c * cam[QW];
        scz_reg <= s * cam[QZ];

        p1_reg[QX] <= 33'(ccx_reg) + 33'(scy_reg);
        p1_reg[QY] <= 33'(ccy_reg) - 33'(scx_reg);
        p1_reg[QZ] <= 33'(ccz_reg) - 33'(scw_reg);
        p1_reg[QW] <= 33'(ccw_reg) + 33'(scz_reg);

        m_reg  <= m_next;
        p2_reg <= p2_next;
    end

    assign out_valid = vld_reg[PROD_LAT-1];
    assign p2        = p2_reg;

endmodule

### rtl/cbpt_quat_norm.sv
module cbpt_quat_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cbpt_pkg::prod_t p [4],
    output logic            out_valid,
    output cbpt_pkg::q15_t  q [4]
);
    import cbpt_pkg::*;

    logic [NORM_LAT-1:0] vld_reg;

    prod_t            p1_reg [4];
    logic [P2_W-1:0]  or_reg;
    prod_t            p2_reg [4];
    logic [LEN_W-1:0] len_reg;
    logic             zero2_reg;
    scaled_t          u3_reg [4];
    logic             zero3_reg;
    scaled_t          u4_reg [4];
    logic [SQ_W-1:0]  sq_reg [4];
    logic             zero4_reg;

    logic [RAD_W-1:0] rx_reg [SQRT_STEPS+1];
    logic [RAD_W-1:0] rr_reg [SQRT_STEPS+1];
    scaled_t          su_reg [SQRT_STEPS+1][4];
    logic             sz_reg [SQRT_STEPS+1];

    logic [REM_W-1:0] rem_reg [DIV_STEPS+1][4];
    logic [16:0]      quo_reg [DIV_STEPS+1][4];
    logic [3:0]       sgn_reg [DIV_STEPS+1];
    logic [DEN_W-1:0] den_reg [DIV_STEPS+1];
    logic             dz_reg  [DIV_STEPS+1];

    q15_t             q_reg [4];

    logic [P2_W-1:0]  or_next;
    logic [LEN_W-1:0] len_next;
    scaled_t          u3_next [4];
    logic [SQ_W-1:0]  sq_next [4];
    logic [RAD_W-1:0] rad_next;
    logic [RAD_W-1:0] rx_next [SQRT_STEPS];
    logic [RAD_W-1:0] rr_next [SQRT_STEPS];
    logic [REM_W-1:0] rem0_next [4];
    logic [3:0]       sgn0_next;
    logic [DEN_W-1:0] den0_next;
    logic [REM_W-1:0] rem_next [DIV_STEPS][4];
    logic [16:0]      quo_next [DIV_STEPS][4];
    q15_t             q_next [4];

    always_comb
    begin
        logic [P2_W-1:0] mag;
        or_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag     = p[i][P2_W-1] ? P2_W'(-p[i]) : P2_W'(p[i]);
            or_next = or_next | mag;
        end
    end

    always_comb
    begin
        len_next = '0;
        for (int i = 0; i < P2_W; i++)
        begin
            if (or_reg[i])
                len_next = LEN_W'(i + 1);
        end
    end

    always_comb
    begin
        prod_t shr;
        prod_t shl;
        for (int i = 0; i < 4; i++)
        begin
            shr = p2_reg[i] >>> (len_reg - LEN_W'(24));
            shl = p2_reg[i] <<< (LEN_W'(24) - len_reg);
            if (len_reg > LEN_W'(24))
                u3_next[i] = shr[U_W-1:0];
            else
                u3_next[i] = shl[U_W-1:0];
        end
    end

    always_comb
    begin
        logic signed [SQ_W:0] sqs;
        rad_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            sqs        = u3_reg[i] * u3_reg[i];
            sq_next[i] = sqs[SQ_W-1:0];
            rad_next   = rad_next + RAD_W'(sq_reg[i]);
        end
    end

    always_comb
    begin
        logic [RAD_W-1:0] bitv;
        logic [RAD_W-1:0] t;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bitv = RAD_W'(1) << (2 * (SQRT_STEPS - 1) - 2 * k);
            t    = rr_reg[k] + bitv;
            if (rx_reg[k] >= t)
            begin
                rx_next[k] = rx_reg[k] - t;
                rr_next[k] = (rr_reg[k] >> 1) + bitv;
            end
            else
            begin
                rx_next[k] = rx_reg[k];
                rr_next[k] = rr_reg[k] >> 1;
            end
        end
    end

    always_comb
    begin
        logic [ROOT_W-1:0] r;
        logic [U_W-1:0]    a;
        r         = rr_reg[SQRT_STEPS][ROOT_W-1:0];
        den0_next = {r, 1'b0};
        for (int i = 0; i < 4; i++)
        begin
            a            = su_reg[SQRT_STEPS][i][U_W-1] ? U_W'(-su_reg[SQRT_STEPS][i])
                                                        : U_W'(su_reg[SQRT_STEPS][i]);
            sgn0_next[i] = su_reg[SQRT_STEPS][i][U_W-1];
            rem0_next[i] = REM_W'({a, 16'b0}) + REM_W'(r);
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] dsh;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dsh = REM_W'(den_reg[j]) << (DIV_STEPS - 1 - j);
            for (int i = 0; i < 4; i++)
            begin
                if (rem_reg[j][i] >= dsh)
                begin
                    rem_next[j][i] = rem_reg[j][i] - dsh;
                    quo_next[j][i] = quo_reg[j][i] | (17'd1 << (DIV_STEPS - 1 - j));
                end
                else
                begin
                    rem_next[j][i] = rem_reg[j][i];
                    quo_next[j][i] = quo_reg[j][i];
                end
            end
        end
    end

    always_comb
    begin
        logic [16:0] v;
        for (int i = 0; i < 4; i++)
        begin
            v = quo_reg[DIV_STEPS][i];
            if (dz_reg[DIV_STEPS])
                q_next[i] = '0;
            else if (!sgn_reg[DIV_STEPS][i])
                q_next[i] = (v > 17'd32767) ? 16'sh7fff : $signed(v[15:0]);
            else
                q_next[i] = (v > 17'd32768) ? 16'sh8000 : $signed(-v[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NORM_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p;
        or_reg    <= or_next;

        p2_reg    <= p1_reg;
        len_reg   <= len_next;
        zero2_reg <= (or_reg == '0);

        u3_reg    <= u3_next;
        zero3_reg <= zero2_reg;

        u4_reg    <= u3_reg;
        sq_reg    <= sq_next;
        zero4_reg <= zero3_reg;

        rx_reg[0] <= rad_next;
        rr_reg[0] <= '0;
        su_reg[0] <= u4_reg;
        sz_reg[0] <= zero4_reg;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rx_reg[k+1] <= rx_next[k];
            rr_reg[k+1] <= rr_next[k];
            su_reg[k+1] <= su_reg[k];
            sz_reg[k+1] <= sz_reg[k];
        end

        rem_reg[0] <= rem0_next;
        quo_reg[0] <= '{default: '0};
        sgn_reg[0] <= sgn0_next;
        den_reg[0] <= den0_next;
        dz_reg[0]  <= sz_reg[SQRT_STEPS];
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            rem_reg[j+1] <= rem_next[j];
            quo_reg[j+1] <= quo_next[j];
            sgn_reg[j+1] <= sgn_reg[j];
            den_reg[j+1] <= den_reg[j];
            dz_reg[j+1]  <= dz_reg[j];
        end

        q_reg <= q_next;
    end

    assign out_valid = vld_reg[NORM_LAT-1];
    assign q         = q_reg;

endmodule

### rtl/camera_to_body_pose_transform_unit.sv
// Throughput: one transaction per cycle; busy stays low and start may be held high.
// Depth is set by the quaternion path: product, normalising shift, 26-stage square root
// and 17-stage divider, one step per stage.
// Reset clears all valid bits and loads the default yaw and mount quaternion.
// done marks each result for one cycle and cannot be held off by the receiver.
module camera_to_body_pose_transform_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cbpt_pkg::cbpt_in_t              pose_in,
    output logic                            done,
    output cbpt_pkg::cbpt_out_t             pose_out,
    input  logic                            wr_en,
    input  logic [cbpt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [15:0]                     wr_data
);
    import cbpt_pkg::*;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_dly_t;

    q15_t half_gamma_cos_reg;
    q15_t half_gamma_sin_reg;
    q15_t mount_quat_reg [4];

    logic     accept;
    q15_t     cam [4];
    logic     pos_valid;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic     prod_valid;
    prod_t    p2 [4];
    logic     norm_valid;
    q15_t     nq [4];
    pos_dly_t dly_reg [NORM_LAT];

    assign accept = start && !busy;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_gamma_cos_reg <= RST_HALF_GAMMA_COS;
            half_gamma_sin_reg <= RST_HALF_GAMMA_SIN;
            mount_quat_reg[QX] <= RST_MOUNT_QUAT_X;
            mount_quat_reg[QY] <= RST_MOUNT_QUAT_Y;
            mount_quat_reg[QZ] <= RST_MOUNT_QUAT_Z;
            mount_quat_reg[QW] <= RST_MOUNT_QUAT_W;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_HALF_GAMMA_COS: half_gamma_cos_reg <= wr_data;
                CFG_HALF_GAMMA_SIN: half_gamma_sin_reg <= wr_data;
                CFG_MOUNT_QUAT_X:   mount_quat_reg[QX] <= wr_data;
                CFG_MOUNT_QUAT_Y:   mount_quat_reg[QY] <= wr_data;
                CFG_MOUNT_QUAT_Z:   mount_quat_reg[QZ] <= wr_data;
                CFG_MOUNT_QUAT_W:   mount_quat_reg[QW] <= wr_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cam[QX] = pose_in.cam_quat_x;
        cam[QY] = pose_in.cam_quat_y;
        cam[QZ] = pose_in.cam_quat_z;
        cam[QW] = pose_in.cam_quat_w;
    end

    cbpt_pos_rot u_pos_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .c         (half_gamma_cos_reg),
        .s         (half_gamma_sin_reg),
        .px        (pose_in.cam_pos_x),
        .py        (pose_in.cam_pos_y),
        .pz        (pose_in.cam_pos_z),
        .out_valid (pos_valid),
        .bx        (pos_x),
        .by        (pos_y),
        .bz        (pos_z)
    );

    cbpt_quat_prod u_quat_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .c         (half_gamma_cos_reg),
        .s         (half_gamma_sin_reg),
        .cam       (cam),
        .mnt       (mount_quat_reg),
        .out_valid (prod_valid),
        .p2        (p2)
    );

    cbpt_quat_norm u_quat_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .p         (p2),
        .out_valid (norm_valid),
        .q         (nq)
    );

    // hold the position until the orientation catches up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NORM_LAT; k++)
            begin
                dly_reg[k] <= '0;
            end
        end
        else
        begin
            dly_reg[0] <= '{vld: pos_valid, x: pos_x, y: pos_y, z: pos_z};
            for (int k = 1; k < NORM_LAT; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign done = norm_valid && dly_reg[NORM_LAT-1].vld;

    always_comb
    begin
        pose_out.body_pos_x  = dly_reg[NORM_LAT-1].x;
        pose_out.body_pos_y  = dly_reg[NORM_LAT-1].y;
        pose_out.body_pos_z  = dly_reg[NORM_LAT-1].z;
        pose_out.body_quat_x = nq[QX];
        pose_out.body_quat_y = nq[QY];
        pose_out.body_quat_z = nq[QZ];
        pose_out.body_quat_w = nq[QW];
    end

endmodule

### tb/camera_to_body_pose_transform_unit_checker.sv
`timescale 1ns / 100ps

module camera_to_body_pose_transform_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  cbpt_pkg::cbpt_in_t              pose_in,
    input  logic                            done,
    input  cbpt_pkg::cbpt_out_t             pose_out,
    input  logic                            wr_en,
    input  logic [cbpt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [15:0]                     wr_data,
    output int                              fail_count,
    output int                              pending
);
    import cbpt_pkg::*;

    longint yaw_cos, yaw_sin;
    longint mount_q [4];
    cbpt_out_t body_pose_q [$];

    assign pending = body_pose_q.size();

    function automatic longint floor_div_pow2(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void hamilton(input longint a [4], input longint b [4],
                                     output longint o [4]);
        o[QW] = a[QW]*b[QW] - a[QX]*b[QX] - a[QY]*b[QY] - a[QZ]*b[QZ];
        o[QX] = a[QW]*b[QX] + a[QX]*b[QW] + a[QY]*b[QZ] - a[QZ]*b[QY];
        o[QY] = a[QW]*b[QY] - a[QX]*b[QZ] + a[QY]*b[QW] + a[QZ]*b[QX];
        o[QZ] = a[QW]*b[QZ] + a[QX]*b[QY] - a[QY]*b[QX] + a[QZ]*b[QW];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 50;
        for (int i = 0; i < 26; i++)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic cbpt_out_t transform_pose(cbpt_in_t p);
        cbpt_out_t o;
        longint cg, sg, px, py, mag, a, sc;
        longint rz [4], cam [4], p1 [4], p2 [4], u [4], nq [4];
        longint unsigned sumsq, r, v;
        int len;
        px = longint'(p.cam_pos_x);
        py = longint'(p.cam_pos_y);
        cg = yaw_cos*yaw_cos - yaw_sin*yaw_sin;
        sg = 2*yaw_cos*yaw_sin;
        o.body_pos_x = 32'(clamp_s32(floor_div_pow2(cg*px + sg*py + (64'sd1 << 29), 30)));
        o.body_pos_y = 32'(clamp_s32(floor_div_pow2(-sg*px + cg*py + (64'sd1 << 29), 30)));
        o.body_pos_z = p.cam_pos_z;
        rz[QX] = 0;
        rz[QY] = 0;
        rz[QZ] = -yaw_sin;
        rz[QW] = yaw_cos;
        cam[QX] = longint'(p.cam_quat_x);
        cam[QY] = longint'(p.cam_quat_y);
        cam[QZ] = longint'(p.cam_quat_z);
        cam[QW] = longint'(p.cam_quat_w);
        hamilton(rz, cam, p1);
        hamilton(p1, mount_q, p2);
        mag = 0;
        for (int i = 0; i < 4; i++)
        begin
            a = (p2[i] < 0) ? -p2[i] : p2[i];
            if (a > mag)
                mag = a;
        end
        if (mag == 0)
            nq = '{0, 0, 0, 0};
        else
        begin
            len = 0;
            while (len < 64 && (mag >> len) != 0)
                len++;
            sumsq = 0;
            for (int i = 0; i < 4; i++)
            begin
                if (len > 24)
                    u[i] = p2[i] >>> (len - 24);
                else
                    u[i] = p2[i] <<< (24 - len);
                sumsq += longint'(u[i]*u[i]);
            end
            r = root_floor(sumsq);
            for (int i = 0; i < 4; i++)
            begin
                a = (u[i] < 0) ? -u[i] : u[i];
                v = (longint'(a) * 65536 + r) / (2*r);
                sc = longint'(v);
                if (u[i] < 0)
                    sc = -sc;
                if (sc > 32767)
                    sc = 32767;
                if (sc < -32768)
                    sc = -32768;
                nq[i] = sc;
            end
        end
        o.body_quat_x = 16'(nq[QX]);
        o.body_quat_y = 16'(nq[QY]);
        o.body_quat_z = 16'(nq[QZ]);
        o.body_quat_w = 16'(nq[QW]);
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cbpt_out_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            yaw_cos = RST_HALF_GAMMA_COS;
            yaw_sin = RST_HALF_GAMMA_SIN;
            mount_q[QX] = RST_MOUNT_QUAT_X;
            mount_q[QY] = RST_MOUNT_QUAT_Y;
            mount_q[QZ] = RST_MOUNT_QUAT_Z;
            mount_q[QW] = RST_MOUNT_QUAT_W;
            body_pose_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (body_pose_q.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = body_pose_q.pop_front();
                    if (pose_out.body_pos_x !== want.body_pos_x)
                        report_mismatch("body_pos_x", pose_out.body_pos_x, want.body_pos_x);
                    if (pose_out.body_pos_y !== want.body_pos_y)
                        report_mismatch("body_pos_y", pose_out.body_pos_y, want.body_pos_y);
                    if (pose_out.body_pos_z !== want.body_pos_z)
                        report_mismatch("body_pos_z", pose_out.body_pos_z, want.body_pos_z);
                    if (pose_out.body_quat_x !== want.body_quat_x)
                        report_mismatch("body_quat_x", pose_out.body_quat_x, want.body_quat_x);
                    if (pose_out.body_quat_y !== want.body_quat_y)
                        report_mismatch("body_quat_y", pose_out.body_quat_y, want.body_quat_y);
                    if (pose_out.body_quat_z !== want.body_quat_z)
                        report_mismatch("body_quat_z", pose_out.body_quat_z, want.body_quat_z);
                    if (pose_out.body_quat_w !== want.body_quat_w)
                        report_mismatch("body_quat_w", pose_out.body_quat_w, want.body_quat_w);
                end
            end
            if (start && !busy)
                body_pose_q.push_back(transform_pose(pose_in));
            if (wr_en)
            begin
                case (wr_index)
                    CFG_HALF_GAMMA_COS: yaw_cos = longint'($signed(wr_data));
                    CFG_HALF_GAMMA_SIN: yaw_sin = longint'($signed(wr_data));
                    CFG_MOUNT_QUAT_X:   mount_q[QX] = longint'($signed(wr_data));
                    CFG_MOUNT_QUAT_Y:   mount_q[QY] = longint'($signed(wr_data));
                    CFG_MOUNT_QUAT_Z:   mount_q[QZ] = longint'($signed(wr_data));
                    CFG_MOUNT_QUAT_W:   mount_q[QW] = longint'($signed(wr_data));
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/camera_to_body_pose_transform_unit_tb.sv
`timescale 1ns / 100ps

module camera_to_body_pose_transform_unit_tb;
    import cbpt_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cbpt_in_t             pose_in;
    logic                 done;
    cbpt_out_t            pose_out;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [15:0]          wr_data;
    int                   fail_count;
    int                   pending;
    int                   pose_total;

    camera_to_body_pose_transform_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pose_in  (pose_in),
        .done     (done),
        .pose_out (pose_out),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    camera_to_body_pose_transform_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pose_in    (pose_in),
        .done       (done),
        .pose_out   (pose_out),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'($signed(16'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic send_pose(cbpt_in_t p, bit allow_gap);
        @(negedge clk);
        if (allow_gap)
            while ($urandom_range(0, 99) < 26)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        start <= 1'b1;
        pose_in <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pose_total++;
    endtask

    task automatic send_rand(int count, bit allow_gap);
        cbpt_in_t p;
        for (int i = 0; i < count; i++)
        begin
            p.cam_pos_x = pick_pos();
            p.cam_pos_y = pick_pos();
            p.cam_pos_z = pick_pos();
            p.cam_quat_x = pick_q15();
            p.cam_quat_y = pick_q15();
            p.cam_quat_z = pick_q15();
            p.cam_quat_w = pick_q15();
            send_pose(p, allow_gap);
        end
    endtask

    task automatic load_config(logic [15:0] c, logic [15:0] s, logic [15:0] mx,
                               logic [15:0] my, logic [15:0] mz, logic [15:0] mw);
        write_reg(CFG_HALF_GAMMA_COS, c);
        write_reg(CFG_HALF_GAMMA_SIN, s);
        write_reg(CFG_MOUNT_QUAT_X, mx);
        write_reg(CFG_MOUNT_QUAT_Y, my);
        write_reg(CFG_MOUNT_QUAT_Z, mz);
        write_reg(CFG_MOUNT_QUAT_W, mw);
    endtask

    initial
    begin
        cbpt_in_t p;
        rst_n = 1'b0;
        start = 1'b0;
        pose_in = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        pose_total = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        send_pose(p, 1'b0);
        p = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        send_pose(p, 1'b0);
        p = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0};
        send_pose(p, 1'b0);
        p = '{32'h0001_0000, 32'hffff_0000, 32'h1, 16'h0, 16'h0, 16'h0, 16'h1};
        send_pose(p, 1'b0);
        p = '{32'h0, 32'h0, 32'hffff_ffff, 16'h7fff, 16'h0, 16'h0, 16'h0};
        send_pose(p, 1'b0);
        send_rand(8, 1'b1);
        drain_pipeline();

        // non-unit trig pair and extreme mount values
        load_config(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0, 16'h7fff);
        p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h7fff, 16'h8000, 16'h1, 16'h7fff};
        send_pose(p, 1'b0);
        send_rand(10, 1'b1);
        drain_pipeline();

        load_config(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_rand(5, 1'b0);
        drain_pipeline();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
                load_config(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff);
            else
                load_config(pick_q15(), pick_q15(), pick_q15(), pick_q15(),
                            pick_q15(), pick_q15());
            send_rand(60, ph != 2);
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### camera_to_body_pose_transform_unit.f
rtl/cbpt_pkg.sv
rtl/cbpt_pos_rot.sv
rtl/cbpt_quat_prod.sv
rtl/cbpt_quat_norm.sv
rtl/camera_to_body_pose_transform_unit.sv
tb/camera_to_body_pose_transform_unit_checker.sv
tb/camera_to_body_pose_transform_unit_tb.sv
